[rtl/irps_pkg.sv]
// ----------------------------------------------------------------------------
// irps_pkg
// Shared types, codes and constant frame patterns for the pulse frame sender.
// ----------------------------------------------------------------------------
package irps_pkg;

    // Number of bytes in a zone frame; values above 16 are treated as 16.
    localparam int FRAME_BYTES = 15;
    localparam int ZBYTES      = (FRAME_BYTES > 16) ? 16 : FRAME_BYTES;
    localparam int FRAME_W     = ZBYTES * 8;
    localparam int PROG_BITS   = 56;
    // Wide enough for frame length plus the extra and stop bits, plus one.
    localparam int LEN_W       = $clog2(FRAME_W + 3);
    localparam int TICK_W      = 19;

    localparam logic [7:0] TIME_MAX   = 8'd240;
    localparam logic [5:0] ZONE_MAX   = 6'd48;
    localparam logic [6:0] ZONE_OFS_A = 7'h17;
    localparam logic [6:0] ZONE_OFS_B = 7'h23;
    localparam logic [6:0] ZONE_OFS_C = 7'h2f;

    localparam logic [7:0] ZONE_BASE [16] = '{
        8'hff, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h00, 8'h04,
        8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'hb8, 8'h3f, 8'h00
    };
    localparam logic [PROG_BITS-1:0] PROG_BASE = 56'hff_40_03_96_09_bd_7f;

    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [TICK_W-1:0]  ticks_t;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_ZONE_ON  = 2'd1,
        MODE_ZONE_OFF = 2'd2,
        MODE_PROGRAM  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_BAD_ZONE    = 3'd1,
        STAT_BAD_TIME    = 3'd2,
        STAT_BAD_PROGRAM = 3'd3,
        STAT_BUSY        = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        REG_SHORT_TICKS  = 3'd0,
        REG_LONG_TICKS   = 3'd1,
        REG_START_TICKS  = 3'd2,
        REG_RST_HI_TICKS = 3'd3,
        REG_RST_LO_TICKS = 3'd4,
        REG_DUR_LIMIT    = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_HI,
        PH_RST_LO,
        PH_START_HI,
        PH_START_LO,
        PH_BIT_HI,
        PH_BIT_LO
    } phase_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] zone;
        logic [7:0] minutes;
        logic [2:0] program_req;
    } in_item_t;

    typedef struct packed {
        logic       line;
        logic       busy_res;
        logic [2:0] status;
    } out_item_t;

    typedef struct packed {
        ticks_t     short_ticks;
        ticks_t     long_ticks;
        ticks_t     start_ticks;
        ticks_t     reset_high_ticks;
        ticks_t     reset_low_ticks;
        logic [7:0] duration_limit;
    } cfg_t;

    // Outcome of checking and building one command.
    typedef struct packed {
        logic    ok;
        status_t status;
        frame_t  frame;
        len_t    len;
        logic    extra;
    } build_t;

    // Zone frame pattern before the fields are written, first bit in the MSB.
    function automatic frame_t zone_base_frame();
        frame_t f;
        f = '0;
        for (int i = 0; i < ZBYTES; i++) begin
            f[FRAME_W-1-8*i -: 8] = (i < 15) ? ZONE_BASE[i] : 8'h00;
        end
        return f;
    endfunction

endpackage

[rtl/irrigation_remote_pulse_frame_sender.sv]
// ----------------------------------------------------------------------------
// irrigation_remote_pulse_frame_sender
// Pulse-width coded command frame sender for an irrigation remote wire.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                              Direction  Carries
//  -------   ---------------------------------  ---------  ---------------------
//  command   s_valid, s_ready, s_item           in         tick or command
//  result    m_valid, m_ready, m_item           out        line, busy, status
//  config    cfg_valid, cfg_ready, cfg_index,   in         register writes
//            cfg_data
//
// Every transaction on the command channel produces exactly one result
// transaction. An item is held in the input register, then the check,
// frame build and phase step run combinationally and write the result
// register, so the block sustains one item per cycle while m_ready is high.
// Backpressure on m_ready stalls the input register, which in turn holds
// s_ready low; both registers stay full while stalled. Reset is synchronous
// and active low: the line goes low, the sequencer idles, and all
// configuration registers return to their default values.
//
module irrigation_remote_pulse_frame_sender (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  irps_pkg::in_item_t  s_item,

    output logic                m_valid,
    input  logic                m_ready,
    output irps_pkg::out_item_t m_item,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [18:0]         cfg_data
);

    // Input register stage.
    logic                in_valid_reg;
    irps_pkg::in_item_t  in_item_reg;

    // Result register stage.
    logic                out_valid_reg;
    irps_pkg::out_item_t out_item_reg;

    // Configuration registers.
    irps_pkg::cfg_t      cfg_reg;

    logic                step_en;
    logic                is_tick;
    irps_pkg::build_t    build;
    irps_pkg::out_item_t result;

    // The compute stage fires when it holds an item and the result register
    // is free or is being emptied in this same cycle.
    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;
    assign is_tick = (irps_pkg::mode_t'(in_item_reg.mode) == irps_pkg::MODE_TICK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    // Configuration writes are always taken; indexes outside the list are
    // ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_ticks      <= 19'd208;
            cfg_reg.long_ticks       <= 19'd1875;
            cfg_reg.start_ticks      <= 19'd900;
            cfg_reg.reset_high_ticks <= 19'd325000;
            cfg_reg.reset_low_ticks  <= 19'd65000;
            cfg_reg.duration_limit   <= 8'd240;
        end else if (cfg_valid) begin
            unique case (irps_pkg::reg_index_t'(cfg_index))
                irps_pkg::REG_SHORT_TICKS:  cfg_reg.short_ticks      <= cfg_data;
                irps_pkg::REG_LONG_TICKS:   cfg_reg.long_ticks       <= cfg_data;
                irps_pkg::REG_START_TICKS:  cfg_reg.start_ticks      <= cfg_data;
                irps_pkg::REG_RST_HI_TICKS: cfg_reg.reset_high_ticks <= cfg_data;
                irps_pkg::REG_RST_LO_TICKS: cfg_reg.reset_low_ticks  <= cfg_data;
                irps_pkg::REG_DUR_LIMIT:    cfg_reg.duration_limit   <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Command check and frame assembly for the item in the input register.
    irps_frame_build u_frame_build (
        .item           (in_item_reg),
        .duration_limit (cfg_reg.duration_limit),
        .build          (build)
    );

    // Pulse timing state; its next-state outputs form the result.
    irps_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .is_tick (is_tick),
        .build   (build),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Every accepted item reaches the result register: a full input stage
    // with a free output stage must fire.
    a_no_stall_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |-> step_en)
        else $error("compute stage stalled with free result register");

    // A result waiting for m_ready is not overwritten.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> out_valid_reg && $stable(out_item_reg))
        else $error("pending result changed");

    // The busy flag of a result always reports idle with a low line.
    a_idle_line_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && !result.busy_res) |-> !result.line)
        else $error("line high while idle");

endmodule

[rtl/irps_frame_build.sv]
// ----------------------------------------------------------------------------
// irps_frame_build
// Checks a command and builds its zone or program frame, first bit in the MSB.
// ----------------------------------------------------------------------------
module irps_frame_build (
    input  irps_pkg::in_item_t item,
    input  logic [7:0]         duration_limit,
    output irps_pkg::build_t   build
);

    // Writes a field LSB first at rising frame positions; bits past the end
    // of the frame are dropped.
    function automatic irps_pkg::frame_t put_field(
        input irps_pkg::frame_t f,
        input int               pos,
        input logic [7:0]       val,
        input int               len
    );
        irps_pkg::frame_t r;
        r = f;
        for (int k = 0; k < len; k++) begin
            if (pos + k < irps_pkg::FRAME_W) begin
                r[irps_pkg::FRAME_W-1-(pos+k)] = val[k];
            end
        end
        return r;
    endfunction

    logic [7:0]       time_val;
    logic [7:0]       zone_a;
    logic [7:0]       zone_b;
    logic [7:0]       zone_c;
    logic [7:0]       zone_m1;
    logic [7:0]       prog_m1;
    logic [7:0]       bank_sel;
    irps_pkg::frame_t zone_frame;
    irps_pkg::frame_t prog_frame;

    always_comb begin
        if (irps_pkg::mode_t'(item.mode) == irps_pkg::MODE_ZONE_ON) begin
            time_val = (item.minutes < duration_limit) ? item.minutes : duration_limit;
        end else begin
            time_val = 8'd0;
        end
    end

    assign zone_a   = {1'b0, 7'({1'b0, item.zone} + irps_pkg::ZONE_OFS_A)};
    assign zone_b   = {1'b0, 7'({1'b0, item.zone} + irps_pkg::ZONE_OFS_B)};
    assign zone_c   = {1'b0, 7'({1'b0, item.zone} + irps_pkg::ZONE_OFS_C)};
    assign zone_m1  = {2'b00, 6'(item.zone - 6'd1)};
    assign prog_m1  = {5'b00000, 3'(item.program_req - 3'd1)};
    assign bank_sel = (item.zone > 6'd12) ? 8'd1 : 8'd2;

    always_comb begin
        zone_frame = irps_pkg::zone_base_frame();
        zone_frame = put_field(zone_frame, 9,   bank_sel, 2);
        zone_frame = put_field(zone_frame, 23,  zone_a, 7);
        zone_frame = put_field(zone_frame, 36,  zone_a, 7);
        zone_frame = put_field(zone_frame, 49,  zone_b, 7);
        zone_frame = put_field(zone_frame, 62,  zone_b, 7);
        zone_frame = put_field(zone_frame, 75,  zone_c, 7);
        zone_frame = put_field(zone_frame, 88,  zone_c, 7);
        zone_frame = put_field(zone_frame, 31,  time_val, 4);
        zone_frame = put_field(zone_frame, 44,  {4'd0, time_val[7:4]}, 4);
        zone_frame = put_field(zone_frame, 57,  time_val, 4);
        zone_frame = put_field(zone_frame, 70,  {4'd0, time_val[7:4]}, 4);
        zone_frame = put_field(zone_frame, 83,  time_val, 4);
        zone_frame = put_field(zone_frame, 96,  {4'd0, time_val[7:4]}, 4);
        zone_frame = put_field(zone_frame, 109, zone_m1, 4);
    end

    always_comb begin
        prog_frame = irps_pkg::frame_t'(irps_pkg::PROG_BASE)
                     << (irps_pkg::FRAME_W - irps_pkg::PROG_BITS);
        prog_frame = put_field(prog_frame, 31, prog_m1, 2);
    end

    always_comb begin
        build.ok     = 1'b0;
        build.status = irps_pkg::STAT_OK;
        if (irps_pkg::mode_t'(item.mode) == irps_pkg::MODE_PROGRAM) begin
            build.frame = prog_frame;
            build.len   = irps_pkg::len_t'(irps_pkg::PROG_BITS);
            build.extra = 1'b0;
            if (item.program_req < 3'd1 || item.program_req > 3'd4) begin
                build.status = irps_pkg::STAT_BAD_PROGRAM;
            end else begin
                build.ok = 1'b1;
            end
        end else begin
            build.frame = zone_frame;
            build.len   = irps_pkg::len_t'(irps_pkg::FRAME_W);
            build.extra = 1'b1;
            if (item.zone < 6'd1 || item.zone > irps_pkg::ZONE_MAX) begin
                build.status = irps_pkg::STAT_BAD_ZONE;
            end else if (time_val > irps_pkg::TIME_MAX) begin
                build.status = irps_pkg::STAT_BAD_TIME;
            end else begin
                build.ok = 1'b1;
            end
        end
    end

endmodule

[rtl/irps_sequencer.sv]
// ----------------------------------------------------------------------------
// irps_sequencer
// Phase state machine that times the reset, start, data, extra and stop pulses.
// ----------------------------------------------------------------------------
module irps_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  logic                is_tick,
    input  irps_pkg::build_t    build,
    input  irps_pkg::cfg_t      cfg,
    output irps_pkg::out_item_t result
);

    irps_pkg::phase_t  phase_reg,   phase_next;
    irps_pkg::ticks_t  count_reg,   count_next;
    irps_pkg::len_t    bit_pos_reg, bit_pos_next;
    irps_pkg::len_t    len_reg,     len_next;
    logic              extra_reg,   extra_next;
    logic              line_reg,    line_next;
    irps_pkg::frame_t  frame_reg,   frame_next;

    irps_pkg::status_t status;
    irps_pkg::len_t    pos_inc;
    irps_pkg::len_t    total;
    logic              cur_bit;
    logic              next_bit;

    // A tick count of zero behaves as one.
    function automatic irps_pkg::ticks_t to_count(input irps_pkg::ticks_t t);
        return (t == '0) ? '0 : irps_pkg::ticks_t'(t - 1'b1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= irps_pkg::PH_IDLE;
            count_reg   <= '0;
            bit_pos_reg <= '0;
            len_reg     <= '0;
            extra_reg   <= 1'b0;
            line_reg    <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            bit_pos_reg <= bit_pos_next;
            len_reg     <= len_next;
            extra_reg   <= extra_next;
            line_reg    <= line_next;
        end
    end

    // The frame is a shift register; while frame bits remain, its MSB is the bit being sent.
    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
    end

    assign pos_inc  = irps_pkg::len_t'(bit_pos_reg + 1'b1);
    assign total    = irps_pkg::len_t'(len_reg + irps_pkg::len_t'(extra_reg) + 1'b1);
    assign cur_bit  = (bit_pos_reg < len_reg) ? frame_reg[irps_pkg::FRAME_W-1]
                                              : (bit_pos_reg == len_reg) && extra_reg;
    assign next_bit = (pos_inc < len_reg) ? frame_reg[irps_pkg::FRAME_W-2]
                                          : (pos_inc == len_reg) && extra_reg;

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        bit_pos_next = bit_pos_reg;
        len_next     = len_reg;
        extra_next   = extra_reg;
        line_next    = line_reg;
        frame_next   = frame_reg;
        status       = irps_pkg::STAT_OK;

        if (step_en) begin
            if (is_tick) begin
                if (phase_reg != irps_pkg::PH_IDLE) begin
                    if (count_reg != '0) begin
                        count_next = irps_pkg::ticks_t'(count_reg - 1'b1);
                    end else begin
                        unique case (phase_reg)
                            irps_pkg::PH_RST_HI: begin
                                phase_next = irps_pkg::PH_RST_LO;
                                line_next  = 1'b0;
                                count_next = to_count(cfg.reset_low_ticks);
                            end
                            irps_pkg::PH_RST_LO: begin
                                phase_next = irps_pkg::PH_START_HI;
                                line_next  = 1'b1;
                                count_next = to_count(cfg.start_ticks);
                            end
                            irps_pkg::PH_START_HI: begin
                                phase_next = irps_pkg::PH_START_LO;
                                line_next  = 1'b0;
                                count_next = to_count(cfg.short_ticks);
                            end
                            irps_pkg::PH_START_LO: begin
                                phase_next   = irps_pkg::PH_BIT_HI;
                                line_next    = 1'b1;
                                bit_pos_next = '0;
                                count_next   = to_count(frame_reg[irps_pkg::FRAME_W-1]
                                                        ? cfg.long_ticks : cfg.short_ticks);
                            end
                            irps_pkg::PH_BIT_HI: begin
                                phase_next = irps_pkg::PH_BIT_LO;
                                line_next  = 1'b0;
                                count_next = to_count(cur_bit ? cfg.short_ticks
                                                              : cfg.long_ticks);
                            end
                            irps_pkg::PH_BIT_LO: begin
                                frame_next = frame_reg << 1;
                                if (pos_inc < total) begin
                                    phase_next   = irps_pkg::PH_BIT_HI;
                                    line_next    = 1'b1;
                                    bit_pos_next = pos_inc;
                                    count_next   = to_count(next_bit ? cfg.long_ticks
                                                                     : cfg.short_ticks);
                                end else begin
                                    phase_next   = irps_pkg::PH_IDLE;
                                    line_next    = 1'b0;
                                    bit_pos_next = '0;
                                    count_next   = '0;
                                end
                            end
                            default: begin
                                phase_next = irps_pkg::PH_IDLE;
                                line_next  = 1'b0;
                                count_next = '0;
                            end
                        endcase
                    end
                end
            end else if (phase_reg != irps_pkg::PH_IDLE) begin
                status = irps_pkg::STAT_BUSY;
            end else if (!build.ok) begin
                status = build.status;
            end else begin
                frame_next   = build.frame;
                len_next     = build.len;
                extra_next   = build.extra;
                bit_pos_next = '0;
                phase_next   = irps_pkg::PH_RST_HI;
                line_next    = 1'b1;
                count_next   = to_count(cfg.reset_high_ticks);
            end
        end
    end

    assign result.line     = line_next;
    assign result.busy_res = (phase_next != irps_pkg::PH_IDLE);
    assign result.status   = status;

    // The line level always follows the phase: high phases drive high.
    a_line_matches_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        line_reg == (phase_reg == irps_pkg::PH_RST_HI ||
                     phase_reg == irps_pkg::PH_START_HI ||
                     phase_reg == irps_pkg::PH_BIT_HI))
        else $error("line level does not match phase");

    // During data bits the position never runs past the last stop bit.
    a_bit_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == irps_pkg::PH_BIT_HI || phase_reg == irps_pkg::PH_BIT_LO)
        |-> bit_pos_reg < total)
        else $error("bit position beyond frame end");

    // A command rejected as busy leaves the frame being sent untouched.
    a_busy_keeps_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && !is_tick && phase_reg != irps_pkg::PH_IDLE)
        |=> $stable(frame_reg) && $stable(len_reg) && $stable(bit_pos_reg))
        else $error("busy command disturbed the frame");

    // Leaving idle only happens on a valid command.
    a_start_on_command: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == irps_pkg::PH_IDLE && phase_next != irps_pkg::PH_IDLE)
        |-> step_en && !is_tick && build.ok)
        else $error("frame started without a valid command");

endmodule
